FILE: hw/rtl/sp2c_pkg.sv
// Package for the polar-to-Cartesian scan converter: widths, register
// indexes, payload types and the quarter-wave sine ROM contents.
// No dependencies.
package sp2c_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int ANGLE_BITS      = 16;

	localparam int QUAD_BITS = ANGLE_BITS - 2;
	localparam int SINE_N    = 1 << SINE_TABLE_BITS;
	localparam int IDX_W     = SINE_TABLE_BITS + 1;
	localparam int MAG_W     = 15;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam cfg_index_t REG_RANGE_LOW       = 2'd0;
	localparam cfg_index_t REG_RANGE_HIGH      = 2'd1;
	localparam cfg_index_t REG_START_ANGLE     = 2'd2;
	localparam cfg_index_t REG_ANGLE_INCREMENT = 2'd3;

	typedef logic [15:0]            range_t;
	typedef logic signed [16:0]     coord_t;
	typedef logic [ANGLE_BITS-1:0]  angle_t;
	typedef logic [IDX_W-1:0]       sine_idx_t;
	typedef logic [MAG_W-1:0]       sine_mag_t;
	typedef logic [SINE_N:0][MAG_W-1:0] sine_rom_t;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Taylor divisors (2n)(2n+1) for n = 1 .. 8
	localparam logic [63:0] SERIES_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// One Q1.15 entry, sin(pi/2 * k / SINE_N), rounded and limited to 32767.
	function automatic sine_mag_t sine_entry(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        v;
		x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		for (int n = 0; n < 8; n++) begin
			term = ((term * x2) >> 30) / SERIES_DIV[n];
			if (n % 2 == 0)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 64'sd0;
		v = (unsigned'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[MAG_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k <= SINE_N; k++)
			rom[k] = sine_entry(k);
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: hw/rtl/scan_polar_to_cartesian.sv
// Laser scan converter: one range sample per beat in, one planar point out.
// Depends on sp2c_pkg (types, register indexes, sine ROM contents).
// Path: index, ROM read and multiply stages, then the output register.
// Throughput: one beat per cycle unless the output is stalled; each stage advances
// when the one after it is empty or moving.
// Reset: config registers to their defaults, beam angle to zero, pipeline empty.
module scan_polar_to_cartesian (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  sp2c_pkg::cfg_index_t cfg_index,
	input  sp2c_pkg::cfg_data_t  cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  sp2c_pkg::range_t   range_mm,
	input  logic               first_sample,
	input  logic               last_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output sp2c_pkg::coord_t   x_mm,
	output sp2c_pkg::coord_t   y_mm,
	output logic               point_valid,
	output logic               scan_end
);
	import sp2c_pkg::*;

	range_t             range_low_q;
	range_t             range_high_q;
	logic [15:0]        start_angle_q;
	logic signed [15:0] angle_increment_q;
	angle_t             beam_q;

	logic [31:0] start_ext;
	logic [31:0] inc_ext;
	angle_t      ang;
	logic [QUAD_BITS-1:0] pos;
	sine_idx_t   idx;
	logic        in_win;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	// stage 1: angle and table index
	logic       v_s1;
	range_t     range_s1;
	logic [1:0] quad_s1;
	sine_idx_t  idx_s1;
	logic       win_s1;
	logic       last_s1;

	// stage 2: ROM read
	logic       v_s2;
	range_t     range_s2;
	sine_mag_t  sin_mag_s2;
	sine_mag_t  cos_mag_s2;
	logic       sin_neg_s2;
	logic       cos_neg_s2;
	logic       win_s2;
	logic       last_s2;
	sine_idx_t  sin_addr;
	sine_idx_t  cos_addr;

	// stage 3: scaled magnitudes
	logic        v_s3;
	logic [15:0] x_mag_s3;
	logic [15:0] y_mag_s3;
	logic        x_neg_s3;
	logic        y_neg_s3;
	logic        win_s3;
	logic        last_s3;
	logic [31:0] x_prod;
	logic [31:0] y_prod;

	logic   out_valid_q;
	coord_t x_mm_q;
	coord_t y_mm_q;
	logic   point_valid_q;
	logic   scan_end_q;

	// each stage advances when the one after it is empty or moving
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q       <= '0;
			range_high_q      <= '1;
			start_angle_q     <= '0;
			angle_increment_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RANGE_LOW:       range_low_q       <= cfg_data;
				REG_RANGE_HIGH:      range_high_q      <= cfg_data;
				REG_START_ANGLE:     start_angle_q     <= cfg_data;
				REG_ANGLE_INCREMENT: angle_increment_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	assign start_ext = 32'(start_angle_q);
	assign inc_ext   = 32'(angle_increment_q);
	assign ang       = first_sample ? start_ext[ANGLE_BITS-1:0] : beam_q;
	assign pos       = ang[QUAD_BITS-1:0];
	assign in_win    = (range_mm >= range_low_q) && (range_mm <= range_high_q);

	// scale the in-quadrant position to the table, rounding half up
	generate
		if (SINE_TABLE_BITS >= QUAD_BITS) begin : g_idx_up
			localparam int UP_SHIFT = SINE_TABLE_BITS - QUAD_BITS;
			assign idx = IDX_W'(pos) << UP_SHIFT;
		end else begin : g_idx_down
			localparam int DN_SHIFT = QUAD_BITS - SINE_TABLE_BITS;
			localparam logic [QUAD_BITS:0] HALF_LSB = (QUAD_BITS + 1)'(1) << (DN_SHIFT - 1);
			logic [QUAD_BITS:0] pos_rnd;
			assign pos_rnd = (QUAD_BITS + 1)'(pos) + HALF_LSB;
			assign idx     = IDX_W'(pos_rnd >> DN_SHIFT);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q <= '0;
			v_s1   <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
			if (in_valid)
				beam_q <= ang + inc_ext[ANGLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			range_s1 <= range_mm;
			quad_s1  <= ang[ANGLE_BITS-1 -: 2];
			idx_s1   <= idx;
			win_s1   <= in_win;
			last_s1  <= last_sample;
		end
	end

	// odd quadrants swap the sine and cosine lookups
	assign sin_addr = quad_s1[0] ? IDX_W'(SINE_N) - idx_s1 : idx_s1;
	assign cos_addr = quad_s1[0] ? idx_s1 : IDX_W'(SINE_N) - idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			sin_mag_s2 <= SINE_ROM[sin_addr];
			cos_mag_s2 <= SINE_ROM[cos_addr];
			sin_neg_s2 <= quad_s1[1];
			cos_neg_s2 <= quad_s1[1] ^ quad_s1[0];
			range_s2   <= range_s1;
			win_s2     <= win_s1;
			last_s2    <= last_s1;
		end
	end

	// r * |c| rounded at bit 15; the sum stays below 2^31
	assign x_prod = 32'(range_s2) * 32'(cos_mag_s2) + 32'd16384;
	assign y_prod = 32'(range_s2) * 32'(sin_mag_s2) + 32'd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy_s3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			x_mag_s3 <= x_prod[30:15];
			y_mag_s3 <= y_prod[30:15];
			x_neg_s3 <= cos_neg_s2;
			y_neg_s3 <= sin_neg_s2;
			win_s3   <= win_s2;
			last_s3  <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (rdy_out)
			out_valid_q <= v_s3;
	end

	// drop the coordinates to zero outside the range window
	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			if (!win_s3) begin
				x_mm_q <= '0;
				y_mm_q <= '0;
			end else begin
				x_mm_q <= x_neg_s3 ? -coord_t'(x_mag_s3) : coord_t'(x_mag_s3);
				y_mm_q <= y_neg_s3 ? -coord_t'(y_mag_s3) : coord_t'(y_mag_s3);
			end
			point_valid_q <= win_s3;
			scan_end_q    <= last_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign x_mm        = x_mm_q;
	assign y_mm        = y_mm_q;
	assign point_valid = point_valid_q;
	assign scan_end    = scan_end_q;

endmodule

FILE: tb/scan_point_checker.sv
// Point checker for the scan converter: follows register writes and input beats,
// predicts every output point and compares it field by field, in order.
// Depends on sp2c_pkg for widths, register indexes and payload types.
module scan_point_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  sp2c_pkg::cfg_index_t cfg_index,
	input  sp2c_pkg::cfg_data_t  cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  sp2c_pkg::range_t     range_mm,
	input  logic                 first_sample,
	input  logic                 last_sample,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  sp2c_pkg::coord_t     x_mm,
	input  sp2c_pkg::coord_t     y_mm,
	input  logic                 point_valid,
	input  logic                 scan_end,
	output int                   errors,
	output int                   pending
);
	import sp2c_pkg::*;

	localparam int TAB_N     = 1 << SINE_TABLE_BITS;
	localparam int IDX_SHIFT = QUAD_BITS - SINE_TABLE_BITS;

	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_t;

	typedef struct {
		coord_t x;
		coord_t y;
		logic   ok;
		logic   fin;
	} point_t;

	int        sine_q15 [0:TAB_N];
	point_t    points [$];
	range_t    win_lo;
	range_t    win_hi;
	angle_t    start_ang;
	angle_t    beam;
	cfg_data_t ang_step;

	// quarter-wave Q1.15 table: Q30 Taylor series through the 17th power
	initial begin : fill_table
		longint unsigned a;
		longint unsigned a2;
		longint unsigned piece;
		longint unsigned q15;
		longint          acc;
		for (int k = 0; k <= TAB_N; k++) begin
			a     = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
			a2    = (a * a) >> 30;
			piece = a;
			acc   = longint'(a);
			for (int n = 1; n <= 8; n++) begin
				piece = ((piece * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					acc = acc - longint'(piece);
				else
					acc = acc + longint'(piece);
			end
			if (acc < 0)
				acc = 0;
			q15 = (64'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
			if (q15 > 64'd32767)
				q15 = 64'd32767;
			sine_q15[k] = int'(q15);
		end
	end

	// round half away from zero
	function automatic coord_t scale_mm(range_t r, int c);
		longint mag;
		longint v;
		mag = (c < 0) ? -c : c;
		v   = (longint'(r) * mag + 16384) >> 15;
		return coord_t'((c < 0) ? -v : v);
	endfunction

	task automatic compare_field(input string what, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (got_v !== want_v) begin
			errors = errors + 1;
			$display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : follow
		angle_t ang;
		int     pos;
		int     idx;
		int     sn;
		int     cs;
		point_t want;
		if (!arst_n) begin
			win_lo    = '0;
			win_hi    = '1;
			start_ang = '0;
			ang_step  = '0;
			beam      = '0;
			points.delete();
			errors    = 0;
			pending  <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_RANGE_LOW:       win_lo    = cfg_data;
					REG_RANGE_HIGH:      win_hi    = cfg_data;
					REG_START_ANGLE:     start_ang = cfg_data;
					REG_ANGLE_INCREMENT: ang_step  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				ang = first_sample ? start_ang : beam;
				pos = int'(ang[QUAD_BITS-1:0]);
				idx = (pos + (1 << (IDX_SHIFT - 1))) >> IDX_SHIFT;
				if (idx > TAB_N)
					idx = TAB_N;
				case (quadrant_t'(ang[ANGLE_BITS-1 -: 2]))
					QUAD_0: begin
						sn = sine_q15[idx];
						cs = sine_q15[TAB_N - idx];
					end
					QUAD_1: begin
						sn = sine_q15[TAB_N - idx];
						cs = -sine_q15[idx];
					end
					QUAD_2: begin
						sn = -sine_q15[idx];
						cs = -sine_q15[TAB_N - idx];
					end
					default: begin
						sn = -sine_q15[TAB_N - idx];
						cs = sine_q15[idx];
					end
				endcase
				want.ok  = (range_mm >= win_lo) && (range_mm <= win_hi);
				want.x   = want.ok ? scale_mm(range_mm, cs) : '0;
				want.y   = want.ok ? scale_mm(range_mm, sn) : '0;
				want.fin = last_sample;
				// advance even for a dropped point; wraps modulo one turn
				beam = ang + angle_t'(ang_step);
				points = {points, want};
			end
			if (out_valid && !out_stall) begin
				if (points.size() == 0) begin
					errors = errors + 1;
					$display("%0t: point with none expected: x=%0d y=%0d valid=%0b end=%0b",
						$time, x_mm, y_mm, point_valid, scan_end);
				end else begin
					want = points.pop_front();
					compare_field("x_mm", want.x, x_mm);
					compare_field("y_mm", want.y, y_mm);
					compare_field("point_valid", want.ok, point_valid);
					compare_field("scan_end", want.fin, scan_end);
				end
			end
			pending <= points.size();
		end
	end

endmodule

FILE: tb/tb.sv
// Top of the scan converter bench: clock, reset, register setup, sample
// stimulus and output back-pressure. Depends on sp2c_pkg, the converter and
// scan_point_checker, which predicts and compares every point.
module tb;
	import sp2c_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 16;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       cfg_wr_en    = 1'b0;
	cfg_index_t cfg_index    = REG_RANGE_LOW;
	cfg_data_t  cfg_data     = '0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	range_t     range_mm     = '0;
	logic       first_sample = 1'b0;
	logic       last_sample  = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	coord_t     x_mm;
	coord_t     y_mm;
	logic       point_valid;
	logic       scan_end;
	int         errors;
	int         pending;
	bit         quiet        = 1'b0;
	bit         hold_ask     = 1'b0;

	scan_polar_to_cartesian uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.range_mm     (range_mm),
		.first_sample (first_sample),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_mm         (x_mm),
		.y_mm         (y_mm),
		.point_valid  (point_valid),
		.scan_end     (scan_end)
	);

	scan_point_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.range_mm     (range_mm),
		.first_sample (first_sample),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_mm         (x_mm),
		.y_mm         (y_mm),
		.point_valid  (point_valid),
		.scan_end     (scan_end),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		for (int n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	// output back-pressure: random bursts, one long hold-off on request
	initial begin : sink
		int   len;
		bit   hold_used;
		logic stall_v;
		hold_used = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_ask && !hold_used) begin
				stall_v   = 1'b1;
				len       = HOLD_CYCLES;
				hold_used = 1'b1;
			end else if (quiet) begin
				stall_v = 1'b0;
				len     = 1;
			end else begin
				stall_v = ($urandom_range(0, 2) == 0);
				len     = $urandom_range(1, 15);
			end
			out_stall <= stall_v;
			repeat (len) @(posedge clk);
		end
	end

	// offer one sample beat and hold it until taken
	task automatic send_sample(input range_t r, input logic f, input logic l);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		range_mm     <= r;
		first_sample <= f;
		last_sample  <= l;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input range_t lo, input range_t hi, input angle_t start,
			input cfg_data_t step);
		wait_drained();
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
		write_reg(REG_START_ANGLE, start);
		write_reg(REG_ANGLE_INCREMENT, step);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		range_t    r;
		range_t    lo;
		range_t    hi;
		cfg_data_t step;
		logic      f;
		logic      l;
		int        len;
		int        sent;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// one turn in eighths, full window: all quadrants, range extremes
		load_settings(16'd0, 16'hFFFF, 16'h0000, 16'h2000);
		send_sample(16'd0, 1'b1, 1'b0);
		send_sample(16'hFFFF, 1'b0, 1'b0);
		send_sample(16'd1, 1'b0, 1'b0);
		send_sample(16'd32768, 1'b0, 1'b0);
		send_sample(16'hFFFF, 1'b0, 1'b0);
		send_sample(16'd12345, 1'b0, 1'b0);
		send_sample(16'hFFFF, 1'b0, 1'b0);
		send_sample(16'd54321, 1'b0, 1'b1);
		send_sample(16'hFFFF, 1'b1, 1'b1);

		// window edges, most negative step, index rounded up to the quadrant top
		load_settings(16'd100, 16'd200, 16'h3FF8, 16'h8000);
		send_sample(16'd99, 1'b1, 1'b0);
		send_sample(16'd100, 1'b0, 1'b0);
		send_sample(16'd200, 1'b0, 1'b0);
		send_sample(16'd201, 1'b0, 1'b1);
		send_sample(16'd150, 1'b0, 1'b0);

		// single-value window at the top, index rounding half up
		load_settings(16'hFFFF, 16'hFFFF, 16'h0008, 16'h7FFF);
		send_sample(16'hFFFF, 1'b1, 1'b0);
		send_sample(16'hFFFE, 1'b0, 1'b1);

		// empty window: nothing valid
		load_settings(16'd500, 16'd400, 16'hFFFF, 16'hFFFF);
		send_sample(16'd450, 1'b1, 1'b0);
		send_sample(16'd400, 1'b0, 1'b0);
		send_sample(16'd500, 1'b0, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase == 0 ? 0 : $urandom_range(0, 4))
				0: begin
					lo = '0;
					hi = '1;
				end
				1: begin
					lo = $urandom();
					hi = $urandom();
					if (lo > hi) begin
						r  = lo;
						lo = hi;
						hi = r;
					end
				end
				2: begin
					lo = $urandom();
					hi = lo;
				end
				3: begin
					lo = $urandom_range(1, 65535);
					hi = $urandom_range(0, lo - 1);
				end
				default: begin
					lo = $urandom_range(0, 20000);
					hi = $urandom_range(40000, 65535);
				end
			endcase
			case ($urandom_range(0, 6))
				0: step = 16'h8000;
				1: step = 16'h7FFF;
				2: step = 16'h0001;
				3: step = 16'hFFFF;
				4: step = 16'h0000;
				default: step = $urandom();
			endcase
			if (phase == PHASES - 1)
				quiet = 1'b1;
			load_settings(lo, hi, angle_t'($urandom()), step);
			if (phase == 1)
				hold_ask <= 1'b1;

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = $urandom_range(1, 40);
				if (len > PHASE_ITEMS - sent)
					len = PHASE_ITEMS - sent;
				for (int j = 0; j < len; j++) begin
					// mostly well-formed scans, some with stray marks
					if ($urandom_range(0, 6) == 0) begin
						f = $urandom_range(0, 1);
						l = $urandom_range(0, 1);
					end else begin
						f = (j == 0);
						l = (j == len - 1);
					end
					case ($urandom_range(0, 5))
						0: r = lo + range_t'($urandom_range(0, 2)) - range_t'(1);
						1: r = hi + range_t'($urandom_range(0, 2)) - range_t'(1);
						default: r = $urandom();
					endcase
					send_sample(r, f, l);
				end
				sent += len;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/sp2c_pkg.sv
hw/rtl/scan_polar_to_cartesian.sv
tb/scan_point_checker.sv
tb/tb.sv
